>>> rtl/uiew_pkg.sv
// Package with types, constants and codes shared by the endpoint walker modules.
package uiew_pkg;

  localparam logic [7:0] DescConfig = 8'h02;
  localparam logic [7:0] DescIface  = 8'h04;
  localparam logic [7:0] DescEp     = 8'h05;
  localparam logic [7:0] DescComp   = 8'h30;
  localparam logic [7:0] AnyId      = 8'hFF;
  localparam logic [1:0] XferIso    = 2'b01;
  localparam logic [7:0] IdReset    = 8'hFF;
  localparam int unsigned QueueDepth = 4;

  // Register indexes on the configuration port.
  localparam logic [3:0] RegClass    = 4'd0;
  localparam logic [3:0] RegSubclass = 4'd4;
  localparam logic [3:0] RegProtocol = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_WALK   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] buffer_length;
  } in_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  endpoint_address;
    logic [7:0]  endpoint_attributes;
    logic [10:0] max_packet_size;
    logic [7:0]  burst_count;
    logic [15:0] interval_bytes;
    logic [7:0]  poll_interval;
    logic [1:0]  iso_mult;
    logic        companion_seen;
    logic        found;
    logic [7:0]  interface_number;
    logic        last;
  } out_word_t;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    logic       emit_pend;   // release the pending endpoint record
    logic       emit_final;  // give the final record after any release
    logic       found;
    logic [7:0] ifnum;
  } act_t;

  function automatic logic id_ok(logic [7:0] r, logic [7:0] v);
    return (r == AnyId) || (r == v);
  endfunction

endpackage

>>> rtl/uiew_front.sv
// Front part: tracks the descriptor walk byte by byte and builds records.
module uiew_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  uiew_pkg::in_word_t  in_word,
  input  logic                q_full,
  output logic                in_stall,
  output logic                q_push,
  output uiew_pkg::act_t      q_act,
  output uiew_pkg::out_word_t q_rec,
  input  logic [7:0]          match_class,
  input  logic [7:0]          match_subclass,
  input  logic [7:0]          match_protocol
);

  uiew_pkg::phase_t phase, phase_next;
  logic [15:0] pos, walk_end, nds, hdr;
  logic [7:0]  clen, ctype;
  logic [31:0] ifs;
  logic        in_match, found_flag, pvalid;
  logic [7:0]  mnum;
  uiew_pkg::out_word_t prec;

  logic [15:0] pos_next, walk_end_next, nds_next, hdr_next;
  logic [7:0]  clen_next, ctype_next, mnum_next;
  logic [31:0] ifs_next;
  logic        in_match_next, found_next, pvalid_next;
  uiew_pkg::out_word_t prec_next;

  logic        acc;
  logic [7:0]  b;
  logic [15:0] off;
  logic [16:0] sum;
  logic [15:0] wmp, nds_c;
  logic        emit_p, emit_f;

  assign in_stall = q_full;
  assign acc = in_valid && !q_full;
  assign b = in_word.data_byte;

  // Walk sequencing and descriptor completion for one accepted byte.
  always_comb begin
    phase_next = phase; pos_next = pos; walk_end_next = walk_end; nds_next = nds;
    hdr_next = hdr; clen_next = clen; ctype_next = ctype; ifs_next = ifs;
    in_match_next = in_match; found_next = found_flag; mnum_next = mnum;
    pvalid_next = pvalid; prec_next = prec;
    emit_p = 1'b0; emit_f = 1'b0;
    off = pos - nds;
    sum = {1'b0, nds} + {9'd0, b};
    wmp = 16'd0; nds_c = 16'd0;
    if (in_word.first_byte) begin
      phase_next = uiew_pkg::PH_IDLE; pos_next = '0; walk_end_next = '0; nds_next = '0;
      hdr_next = '0; clen_next = '0; ctype_next = '0; ifs_next = '0;
      in_match_next = 1'b0; found_next = 1'b0; mnum_next = '0; pvalid_next = 1'b0;
      if (in_word.buffer_length < 16'd9 || b < 8'd9) begin
        emit_f = 1'b1;
      end else begin
        walk_end_next = in_word.buffer_length;
        clen_next = b;
        pos_next = 16'd1;
        phase_next = uiew_pkg::PH_HEADER;
      end
    end else if (phase == uiew_pkg::PH_HEADER) begin
      if (pos == 16'd1) begin
        if (b != uiew_pkg::DescConfig) begin
          emit_f = 1'b1; phase_next = uiew_pkg::PH_IDLE;
        end else begin
          pos_next = 16'd2;
        end
      end else if (pos == 16'd2) begin
        hdr_next = {8'd0, b};
        pos_next = 16'd3;
      end else begin
        hdr_next = {b, hdr[7:0]};
        if (hdr_next < walk_end) walk_end_next = hdr_next;
        nds_next = {8'd0, clen};
        pos_next = 16'd4;
        phase_next = uiew_pkg::PH_WALK;
        if ({1'b0, nds_next} + 17'd2 > {1'b0, walk_end_next}) begin
          emit_f = 1'b1; phase_next = uiew_pkg::PH_IDLE;
        end
      end
    end else if (phase == uiew_pkg::PH_WALK) begin
      pos_next = pos + 16'd1;
      if (pos >= nds) begin
        if (off == 16'd0) begin
          if (b < 8'd2 || sum > {1'b0, walk_end}) begin
            emit_p = pvalid; pvalid_next = 1'b0;
            emit_f = 1'b1; phase_next = uiew_pkg::PH_IDLE;
          end else begin
            clen_next = b; ctype_next = '0; ifs_next = '0; hdr_next = '0;
          end
        end else begin
          if (off == 16'd1) begin
            ctype_next = b;
            if (!(b == uiew_pkg::DescComp && clen >= 8'd6) && pvalid) begin
              emit_p = 1'b1; pvalid_next = 1'b0;
            end
          end else if (off <= 16'd5) begin
            ifs_next = ifs | ({24'd0, b} << {off[1:0] - 2'd2, 3'b000});
          end else if (off <= 16'd7) begin
            hdr_next = hdr | ({8'd0, b} << {off[0], 3'b000});
          end
          if (off == {8'd0, clen} - 16'd1) begin
            nds_c = nds + {8'd0, clen};
            nds_next = nds_c;
            if (ctype_next == uiew_pkg::DescComp && clen >= 8'd6) begin
              if (pvalid_next) begin
                prec_next.burst_count = ifs_next[7:0];
                prec_next.interval_bytes = ifs_next[31:16];
                prec_next.companion_seen = 1'b1;
                if (prec.endpoint_attributes[1:0] == uiew_pkg::XferIso)
                  prec_next.iso_mult = ifs_next[9:8];
              end
            end else if (ctype_next == uiew_pkg::DescIface && clen >= 8'd9) begin
              if (in_match) begin
                emit_f = 1'b1; phase_next = uiew_pkg::PH_IDLE;
              end else if (ifs_next[15:8] == 8'd0
                  && uiew_pkg::id_ok(match_class, ifs_next[31:24])
                  && uiew_pkg::id_ok(match_subclass, hdr_next[7:0])
                  && uiew_pkg::id_ok(match_protocol, hdr_next[15:8])) begin
                in_match_next = 1'b1; found_next = 1'b1; mnum_next = ifs_next[7:0];
              end
            end else if (in_match && ctype_next == uiew_pkg::DescEp && clen >= 8'd7) begin
              wmp = ifs_next[31:16];
              prec_next = '0;
              prec_next.endpoint_address = ifs_next[7:0];
              prec_next.endpoint_attributes = ifs_next[15:8];
              prec_next.max_packet_size = wmp[10:0];
              prec_next.burst_count = {6'd0, wmp[12:11]};
              prec_next.poll_interval = hdr_next[7:0];
              pvalid_next = 1'b1;
            end
            if (!emit_f && {1'b0, nds_c} + 17'd2 > {1'b0, walk_end}) begin
              emit_f = 1'b1; phase_next = uiew_pkg::PH_IDLE;
            end
            if (emit_f && pvalid_next) begin
              emit_p = 1'b1; pvalid_next = 1'b0;
            end
          end
        end
      end
    end
    q_push = acc && (emit_p || emit_f);
    q_act.emit_pend = emit_p;
    q_act.emit_final = emit_f;
    q_act.found = found_next;
    q_act.ifnum = found_next ? mnum_next : 8'd0;
    // The released record includes anything merged by this same byte.
    q_rec = prec_next;
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= uiew_pkg::PH_IDLE; pos <= '0; walk_end <= '0; nds <= '0; hdr <= '0;
      clen <= '0; ctype <= '0; ifs <= '0; in_match <= 1'b0; found_flag <= 1'b0;
      mnum <= '0; pvalid <= 1'b0; prec <= '0;
    end else if (acc) begin
      phase <= phase_next; pos <= pos_next; walk_end <= walk_end_next; nds <= nds_next;
      hdr <= hdr_next; clen <= clen_next; ctype <= ctype_next; ifs <= ifs_next;
      in_match <= in_match_next; found_flag <= found_next; mnum <= mnum_next;
      pvalid <= pvalid_next; prec <= prec_next;
    end
  end

endmodule

>>> rtl/uiew_back.sv
// Back part: queue of classified bytes and the record output stage.
module uiew_back #(
  parameter int unsigned Depth = uiew_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_push,
  input  uiew_pkg::act_t      q_act,
  input  uiew_pkg::out_word_t q_rec,
  output logic                q_full,
  output logic                out_valid,
  input  logic                out_stall,
  output uiew_pkg::out_word_t out_word
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  uiew_pkg::act_t      acts [Depth];
  uiew_pkg::out_word_t recs [Depth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0]   cnt;
  logic          phase2;  // pending record already given, final remains
  logic          pop, empty;
  uiew_pkg::act_t      ha;
  uiew_pkg::out_word_t fin;

  assign empty = (cnt == '0);
  // One entry kept back so the front can push in the same cycle it sees room.
  assign q_full = (cnt >= (Aw+1)'(Depth - 1));
  assign ha = acts[rp];
  assign out_valid = !empty;

  // Present either the pending endpoint record or the final record.
  always_comb begin
    fin = '0;
    fin.record_kind = 1'b1;
    fin.found = ha.found;
    fin.interface_number = ha.ifnum;
    fin.last = 1'b1;
    if (ha.emit_pend && !phase2) out_word = recs[rp];
    else out_word = fin;
    pop = out_valid && !out_stall &&
          (!(ha.emit_pend && !phase2) || !ha.emit_final);
  end

  // Queue pointers and the two-word split.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; phase2 <= 1'b0;
    end else begin
      if (q_push) wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + Aw'(1);
      if (pop) begin
        rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + Aw'(1);
        phase2 <= 1'b0;
      end else if (out_valid && !out_stall) begin
        phase2 <= 1'b1;
      end
      cnt <= cnt + (Aw+1)'(q_push) - (Aw+1)'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (q_push) begin
      acts[wp] <= q_act;
      recs[wp] <= q_rec;
    end
  end

endmodule

>>> rtl/usb_interface_endpoint_walker_core.sv
// Top level of the USB interface endpoint walker.
//   channel | direction | payload              | handshake
//   in      | input     | in_word (in_word_t)  | in_valid / in_stall
//   out     | output    | out_word (out_word_t)| out_valid / out_stall
//   cfg     | input     | match registers      | APB, pready always high
// One byte is taken per cycle; a byte that causes results passes through a
// small queue, and a word with both an endpoint and a final record gives both,
// endpoint first. The front stalls only when the queue is full.
// Reset is synchronous and sets the match registers to 255 and the walk idle.
module usb_interface_endpoint_walker_core #(
  parameter int unsigned QueueDepth = uiew_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  uiew_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output uiew_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] match_class, match_subclass, match_protocol;
  logic q_push, q_full;
  uiew_pkg::act_t q_act;
  uiew_pkg::out_word_t q_rec;

  assign pready = 1'b1;

  // Match registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_class <= uiew_pkg::IdReset;
      match_subclass <= uiew_pkg::IdReset;
      match_protocol <= uiew_pkg::IdReset;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        uiew_pkg::RegClass:    match_class <= pwdata[7:0];
        uiew_pkg::RegSubclass: match_subclass <= pwdata[7:0];
        uiew_pkg::RegProtocol: match_protocol <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr)
      uiew_pkg::RegClass:    prdata = {24'd0, match_class};
      uiew_pkg::RegSubclass: prdata = {24'd0, match_subclass};
      uiew_pkg::RegProtocol: prdata = {24'd0, match_protocol};
      default:               prdata = 32'd0;
    endcase
  end

  uiew_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_word(in_word), .q_full(q_full),
    .in_stall(in_stall), .q_push(q_push), .q_act(q_act), .q_rec(q_rec),
    .match_class(match_class), .match_subclass(match_subclass),
    .match_protocol(match_protocol)
  );

  uiew_back #(.Depth(QueueDepth)) u_back (
    .clk(clk), .rst(rst), .q_push(q_push), .q_act(q_act), .q_rec(q_rec),
    .q_full(q_full), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // A final record always carries the last mark.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.record_kind == out_word.last))
    else $error("record kind and last disagree");
  // An endpoint record never reports a match.
  a_ep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.record_kind) |-> !out_word.found)
    else $error("endpoint record with found set");
  // The front never pushes into a full queue.
  a_push: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");

endmodule

>>> bench/walker_checker.sv
// Checker that predicts and compares the endpoint walker's output records.
module walker_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  uiew_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  uiew_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_addr,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  records_seen,
  output int                  finals_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Match registers as the predictor sees them.
  logic [7:0] m_class, m_sub, m_proto;

  // Walk state of the predictor.
  uiew_pkg::phase_t phase;
  logic [15:0] pos, wend, dstart, hscr;
  logic [7:0]  clen, ctype;
  logic [31:0] iscr;
  logic        in_match, got_match, ep_held;
  logic [7:0]  match_num;
  uiew_pkg::out_word_t ep_rec;

  uiew_pkg::out_word_t expected_records[$];

  assign pending_count = expected_records.size();

  function automatic logic [7:0] desc_byte(int off);
    if (off >= 2 && off <= 5) return iscr[8*(off-2) +: 8];
    if (off == 6 || off == 7) return hscr[8*(off-6) +: 8];
    return 8'd0;
  endfunction

  function automatic logic id_match(logic [7:0] r, logic [7:0] v);
    return (r == uiew_pkg::AnyId) || (r == v);
  endfunction

  task automatic release_endpoint();
    if (ep_held) begin
      expected_records.push_back(ep_rec);
      ep_held = 1'b0;
    end
  endtask

  task automatic close_walk();
    uiew_pkg::out_word_t f;
    release_endpoint();
    f = '0;
    f.record_kind = 1'b1;
    f.found = got_match;
    f.interface_number = got_match ? match_num : 8'd0;
    f.last = 1'b1;
    expected_records.push_back(f);
    phase = uiew_pkg::PH_IDLE;
  endtask

  function automatic logic walk_full();
    return 32'(dstart) + 2 > 32'(wend);
  endfunction

  task automatic clear_walk();
    phase = uiew_pkg::PH_IDLE;
    pos = '0; wend = '0; dstart = '0; hscr = '0;
    clen = '0; ctype = '0; iscr = '0;
    in_match = 0; got_match = 0; ep_held = 0;
    match_num = '0; ep_rec = '0;
  endtask

  // Act on a descriptor once its last byte has been taken.
  task automatic descriptor_done(output logic ended);
    logic [15:0] w;
    ended = 0;
    if (ctype == uiew_pkg::DescComp && clen >= 6) begin
      if (ep_held) begin
        ep_rec.burst_count = desc_byte(2);
        ep_rec.interval_bytes = {desc_byte(5), desc_byte(4)};
        ep_rec.companion_seen = 1'b1;
        if (ep_rec.endpoint_attributes[1:0] == uiew_pkg::XferIso)
          ep_rec.iso_mult = 2'(desc_byte(3));
      end
    end else if (ctype == uiew_pkg::DescIface && clen >= 9) begin
      if (in_match) begin
        close_walk();
        ended = 1;
        return;
      end
      if (desc_byte(3) == 0 && id_match(m_class, desc_byte(5)) &&
          id_match(m_sub, desc_byte(6)) && id_match(m_proto, desc_byte(7))) begin
        in_match = 1; got_match = 1; match_num = desc_byte(2);
      end
    end else if (in_match && ctype == uiew_pkg::DescEp && clen >= 7) begin
      w = {desc_byte(5), desc_byte(4)};
      ep_rec = '0;
      ep_rec.endpoint_address = desc_byte(2);
      ep_rec.endpoint_attributes = desc_byte(3);
      ep_rec.max_packet_size = w[10:0];
      ep_rec.burst_count = {6'd0, w[12:11]};
      ep_rec.poll_interval = desc_byte(6);
      ep_held = 1;
    end
    dstart = dstart + 16'(clen);
    if (walk_full()) begin
      close_walk();
      ended = 1;
    end
  endtask

  // Advance the predictor by one accepted word.
  task automatic take_byte(uiew_pkg::in_word_t w);
    logic [7:0] b;
    logic [15:0] p;
    int off;
    logic ended;
    b = w.data_byte;
    if (w.first_byte) begin
      clear_walk();
      if (w.buffer_length < 9 || b < 9) begin
        close_walk();
        return;
      end
      wend = w.buffer_length; clen = b; pos = 1; phase = uiew_pkg::PH_HEADER;
      return;
    end
    if (phase == uiew_pkg::PH_HEADER) begin
      if (pos == 1) begin
        if (b != uiew_pkg::DescConfig) close_walk();
        else pos = 2;
        return;
      end
      if (pos == 2) begin
        hscr = {8'd0, b}; pos = 3;
        return;
      end
      hscr[15:8] = b;
      if (hscr < wend) wend = hscr;
      dstart = 16'(clen);
      pos = 4;
      phase = uiew_pkg::PH_WALK;
      if (walk_full()) close_walk();
      return;
    end
    if (phase != uiew_pkg::PH_WALK) return;
    p = pos;
    pos = p + 1;
    if (p < dstart) return;
    off = int'(p) - int'(dstart);
    if (off == 0) begin
      if (b < 2 || 32'(dstart) + 32'(b) > 32'(wend)) begin
        close_walk();
        return;
      end
      clen = b; ctype = 0; iscr = 0; hscr = 0;
      return;
    end
    if (off == 1) begin
      ctype = b;
      if (!(b == uiew_pkg::DescComp && clen >= 6)) release_endpoint();
    end else if (off <= 5) begin
      iscr[8*(off-2) +: 8] = b;
    end else if (off <= 7) begin
      hscr[8*(off-6) +: 8] = b;
    end
    if (off == int'(clen) - 1) descriptor_done(ended);
  endtask

  // Follow register writes, words in and records out.
  always @(posedge clk) begin
    uiew_pkg::out_word_t exp_rec;
    if (rst) begin
      m_class <= uiew_pkg::IdReset; m_sub <= uiew_pkg::IdReset;
      m_proto <= uiew_pkg::IdReset;
      clear_walk();
      expected_records.delete();
      fail_count <= 0;
      records_seen <= 0;
      finals_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          uiew_pkg::RegClass:    m_class <= cfg_data;
          uiew_pkg::RegSubclass: m_sub   <= cfg_data;
          uiew_pkg::RegProtocol: m_proto <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        records_seen <= records_seen + 1;
        if (out_word.record_kind) finals_seen <= finals_seen + 1;
        if (expected_records.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected record %h", out_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_rec = expected_records.pop_front();
          if (exp_rec !== out_word) begin
            if (fail_count < 10)
              $display("record mismatch: expected %p, got %p", exp_rec, out_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) take_byte(in_word);
    end
  end
endmodule

>>> bench/testbench.sv
// Top of the endpoint walker testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  uiew_pkg::in_word_t in_word;
  uiew_pkg::out_word_t out_word;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending_count, records_seen, finals_seen;
  int cycles, words_sent;
  logic hold_receiver;
  logic [7:0] buf_bytes[$];

  usb_interface_endpoint_walker_core DUT (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  walker_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_we(psel && penable && pwrite && pready), .cfg_addr(paddr),
    .cfg_data(pwdata[7:0]), .fail_count, .pending_count, .records_seen, .finals_seen
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Receiver stall: mostly short gaps, sometimes long, plus a forced hold.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_receiver) out_stall <= 1;
      else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n - 1) @(negedge clk);
      end else out_stall <= 0;
    end
  end

  function automatic int rnd_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Offer one word and wait until it is taken. Valid stays high afterwards so
  // the next word can follow at once; a gap or a drain lowers it.
  task automatic send_word(logic [7:0] b, logic f, logic [15:0] len, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_word <= '{data_byte: b, first_byte: f, buffer_length: len};
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  // Send a whole buffer; the first byte carries the length.
  task automatic send_buffer(logic [15:0] len, bit gaps);
    foreach (buf_bytes[i])
      send_word(buf_bytes[i], i == 0, (i == 0) ? len : 16'($urandom),
                gaps ? rnd_gap() : 0);
  endtask

  task automatic cfg_write(logic [3:0] a, logic [7:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= a; pwdata <= {24'($urandom), v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Stop offering words and wait until every expected record has come.
  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic add_header(logic [15:0] total);
    buf_bytes.push_back(8'd9); buf_bytes.push_back(uiew_pkg::DescConfig);
    buf_bytes.push_back(total[7:0]); buf_bytes.push_back(total[15:8]);
    repeat (5) buf_bytes.push_back(8'($urandom));
  endtask

  task automatic add_iface(logic [7:0] num, logic [7:0] alt, logic [7:0] c,
                           logic [7:0] s, logic [7:0] p);
    buf_bytes.push_back(8'd9); buf_bytes.push_back(uiew_pkg::DescIface);
    buf_bytes.push_back(num); buf_bytes.push_back(alt);
    buf_bytes.push_back(8'($urandom_range(0, 4)));
    buf_bytes.push_back(c); buf_bytes.push_back(s); buf_bytes.push_back(p);
    buf_bytes.push_back(8'($urandom));
  endtask

  task automatic add_endpoint();
    buf_bytes.push_back(8'd7); buf_bytes.push_back(uiew_pkg::DescEp);
    repeat (5) buf_bytes.push_back(8'($urandom));
  endtask

  task automatic add_companion();
    buf_bytes.push_back(8'd6); buf_bytes.push_back(uiew_pkg::DescComp);
    repeat (4) buf_bytes.push_back(8'($urandom));
  endtask

  // Random but mostly well-formed configuration buffer.
  task automatic build_random(output logic [15:0] len);
    int n_if, n_ep;
    logic [7:0] id;
    buf_bytes.delete();
    add_header(16'd0);
    n_if = $urandom_range(1, 3);
    for (int i = 0; i < n_if; i++) begin
      id = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      add_iface(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0,
                id, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      n_ep = $urandom_range(0, 3);
      repeat (n_ep) begin
        add_endpoint();
        if ($urandom_range(0, 1) == 1) add_companion();
        if ($urandom_range(0, 7) == 0) begin
          // Odd descriptor: random type and length.
          buf_bytes.push_back(8'($urandom_range(2, 12)));
          buf_bytes.push_back(8'($urandom));
          repeat (int'(buf_bytes[buf_bytes.size()-2]) - 2)
            buf_bytes.push_back(8'($urandom));
        end
      end
    end
    len = 16'(buf_bytes.size());
    // Occasional damage: short or all-ones total, corrupt byte, or noise.
    case ($urandom_range(0, 9))
      0: len = 16'($urandom_range(0, buf_bytes.size()));
      1: buf_bytes[$urandom_range(9, buf_bytes.size() - 1)] = 8'($urandom_range(0, 1));
      2: len = 16'hFFFF;
      default: ;
    endcase
    buf_bytes[2] = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'(buf_bytes.size());
    buf_bytes[3] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(buf_bytes.size() >> 8);
  endtask

  initial begin
    logic [15:0] len;
    rst = 1; in_valid = 0; in_word = '0; hold_receiver = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    words_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: bad headers, short buffer, all-ones fields.
    send_word(8'd9, 1, 16'd8, 0);
    send_word(8'd8, 1, 16'd100, 0);
    send_word(8'd9, 1, 16'd100, 0);
    send_word(8'd3, 0, 16'd0, 0);
    send_word(8'hFF, 1, 16'hFFFF, 0);
    send_word(8'hFF, 0, 16'hFFFF, 0);
    send_word(8'h00, 0, 16'h0000, 0);
    // Then a match with endpoint and companion.
    buf_bytes.delete();
    add_header(16'd31); add_iface(8'h5A, 0, 8'h03, 8'h01, 8'h02);
    add_endpoint(); buf_bytes[20] = 8'h01; add_companion();
    send_buffer(16'd31, 0);
    drain();

    // Register extremes, then random buffers at each setting.
    for (int phase_i = 0; phase_i < 6; phase_i++) begin
      case (phase_i)
        0: begin cfg_write(uiew_pkg::RegClass, 8'h00); cfg_write(uiew_pkg::RegSubclass, 8'h00);
                 cfg_write(uiew_pkg::RegProtocol, 8'h00); end
        1: begin cfg_write(uiew_pkg::RegClass, 8'hFF); cfg_write(uiew_pkg::RegSubclass, 8'hFF);
                 cfg_write(uiew_pkg::RegProtocol, 8'hFF); end
        default: begin
          cfg_write(uiew_pkg::RegClass,
                    ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(0, 3)));
          cfg_write(uiew_pkg::RegSubclass,
                    ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(0, 3)));
          cfg_write(uiew_pkg::RegProtocol,
                    ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(0, 3)));
        end
      endcase
      repeat (2) begin
        build_random(len);
        if (phase_i == 2) begin
          // Long receiver hold while words keep coming; the short bad
          // headers each give a final record, so the queue fills up.
          fork
            begin hold_receiver = 1; repeat (200) @(negedge clk); hold_receiver = 0; end
            begin
              repeat (6) send_word(8'd0, 1, 16'd0, 0);
              send_buffer(len, 0);
            end
          join
        end else send_buffer(len, 1);
        if ($urandom_range(0, 4) == 0) send_word(8'($urandom), 0, 16'($urandom), rnd_gap());
      end
      // Sender pauses until every record has come back.
      drain();
    end

    drain();
    $display("sent %0d words; saw %0d records, %0d of them final", words_sent,
             records_seen, finals_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("failures %0d, records still expected %0d", fail_count, pending_count);
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
